// ----- rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W          = 15;
    localparam int UNIT_W         = 13;
    localparam int CH_W           = 8;

    // Fixed-point formats
    localparam int HUE_FRAC_BITS  = 6;
    localparam int UNIT_FRAC_BITS = 12;
    localparam int UNIT           = 1 << UNIT_FRAC_BITS;   // 1.0 in Q1.12
    localparam int SECT           = 60 << HUE_FRAC_BITS;   // 60 degrees
    localparam int SECT_W         = 12;                    // holds 0..SECT
    localparam int NUM_SECT       = 6;

    // Scaled products
    localparam int UNIT_SECT      = UNIT * SECT;           // 1.0 * 60 degrees
    localparam int UP_W           = 24;                    // holds 0..UNIT_SECT
    localparam int PROD_X_W       = 36;                    // value * (UNIT_SECT - s*d)
    localparam int PROD_M_W       = 25;                    // value * (1.0 - s)

    // 60-degree sectors: first letter gets chroma, second the secondary part
    typedef enum logic [2:0] {
        SEC_R_G = 3'd0,
        SEC_G_R = 3'd1,
        SEC_G_B = 3'd2,
        SEC_B_G = 3'd3,
        SEC_B_R = 3'd4,
        SEC_R_B = 3'd5
    } t_sector;

    // After sector decode
    typedef struct packed {
        logic                oor;
        t_sector             sector;
        logic [SECT_W-1:0]   rem;
        logic [UNIT_W-1:0]   sat;
        logic [UNIT_W-1:0]   val;
    } t_sect_info;

    // After the multiplier stages
    typedef struct packed {
        logic                oor;
        t_sector             sector;
        logic [PROD_X_W-1:0] vt;
        logic [PROD_M_W-1:0] vum;
        logic [UNIT_W-1:0]   val;
    } t_prod;

endpackage

// ----- rtl/hsv2rgb_sector.sv -----
module hsv2rgb_sector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]    i_hue,
    input  logic [hsv2rgb_pkg::UNIT_W-1:0]   i_saturation,
    input  logic [hsv2rgb_pkg::UNIT_W-1:0]   i_brightness,
    output logic                             o_valid,
    output hsv2rgb_pkg::t_sect_info          o_info
);

    logic                              r_valid;
    hsv2rgb_pkg::t_sect_info           r_info;
    hsv2rgb_pkg::t_sect_info           n_info;
    logic [2:0]                        cnt;
    logic [hsv2rgb_pkg::HUE_W-1:0]     diff;

    // Sector index from parallel compares against the sector boundaries
    always_comb begin
        cnt = 3'd0;
        for (int k = 1; k < hsv2rgb_pkg::NUM_SECT; k++) begin
            if (i_hue >= hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::SECT)) begin
                cnt = cnt + 3'd1;
            end
        end
        diff = i_hue - hsv2rgb_pkg::HUE_W'(cnt) * hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECT);

        n_info.oor    = i_hue >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::NUM_SECT * hsv2rgb_pkg::SECT);
        n_info.sector = hsv2rgb_pkg::t_sector'(cnt);
        n_info.rem    = diff[hsv2rgb_pkg::SECT_W-1:0];
        // Clamp to 1.0
        n_info.sat    = (i_saturation > hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::UNIT)) ?
                        hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::UNIT) : i_saturation;
        n_info.val    = (i_brightness > hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::UNIT)) ?
                        hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::UNIT) : i_brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_info <= n_info;
    end

    assign o_valid = r_valid;
    assign o_info  = r_info;

endmodule

// ----- rtl/hsv2rgb_chroma.sv -----
module hsv2rgb_chroma (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  hsv2rgb_pkg::t_sect_info     i_info,
    output logic                        o_valid,
    output hsv2rgb_pkg::t_prod          o_prod
);

    // Stage B: distance from the sector peak and saturation * distance
    logic                              r_b_valid;
    logic                              r_b_oor;
    hsv2rgb_pkg::t_sector              r_b_sector;
    logic [hsv2rgb_pkg::UP_W-1:0]      r_sd;
    logic [hsv2rgb_pkg::UNIT_W-1:0]    r_um;
    logic [hsv2rgb_pkg::UNIT_W-1:0]    r_b_val;
    logic                              sec_odd;
    logic [hsv2rgb_pkg::SECT_W-1:0]    peak_dist;
    logic [hsv2rgb_pkg::UP_W-1:0]      n_sd;
    logic [hsv2rgb_pkg::UNIT_W-1:0]    n_um;

    // Stage C: value times the two scaled factors
    logic                              r_c_valid;
    hsv2rgb_pkg::t_prod                r_prod;
    hsv2rgb_pkg::t_prod                n_prod;
    logic [hsv2rgb_pkg::UP_W-1:0]      tfac;

    always_comb begin
        sec_odd   = (i_info.sector == hsv2rgb_pkg::SEC_G_R) ||
                    (i_info.sector == hsv2rgb_pkg::SEC_B_G) ||
                    (i_info.sector == hsv2rgb_pkg::SEC_R_B);
        peak_dist = sec_odd ? i_info.rem :
                    hsv2rgb_pkg::SECT_W'(hsv2rgb_pkg::SECT) - i_info.rem;
        n_sd      = hsv2rgb_pkg::UP_W'(i_info.sat) * hsv2rgb_pkg::UP_W'(peak_dist);
        n_um      = hsv2rgb_pkg::UNIT_W'(hsv2rgb_pkg::UNIT) - i_info.sat;
    end

    always_comb begin
        tfac          = hsv2rgb_pkg::UP_W'(hsv2rgb_pkg::UNIT_SECT) - r_sd;
        n_prod.oor    = r_b_oor;
        n_prod.sector = r_b_sector;
        n_prod.vt     = hsv2rgb_pkg::PROD_X_W'(r_b_val) * hsv2rgb_pkg::PROD_X_W'(tfac);
        n_prod.vum    = hsv2rgb_pkg::PROD_M_W'(r_b_val) * hsv2rgb_pkg::PROD_M_W'(r_um);
        n_prod.val    = r_b_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_oor    <= i_info.oor;
        r_b_sector <= i_info.sector;
        r_sd       <= n_sd;
        r_um       <= n_um;
        r_b_val    <= i_info.val;
        r_prod     <= n_prod;
    end

    assign o_valid = r_c_valid;
    assign o_prod  = r_prod;

endmodule

// ----- rtl/hsv2rgb_place.sv -----
module hsv2rgb_place (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  hsv2rgb_pkg::t_prod             i_prod,
    output logic                           o_valid,
    output logic [hsv2rgb_pkg::CH_W-1:0]   o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]   o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]   o_blue
);

    localparam int XS_W = hsv2rgb_pkg::PROD_X_W + 4;       // times 17
    localparam int MS_W = hsv2rgb_pkg::PROD_M_W + 8;       // times 255
    localparam int CS_W = hsv2rgb_pkg::UNIT_W + 8;         // times 255
    localparam int X_LO = 2 * hsv2rgb_pkg::UNIT_FRAC_BITS + 8;
    localparam int M_LO = 2 * hsv2rgb_pkg::UNIT_FRAC_BITS;
    localparam int C_LO = hsv2rgb_pkg::UNIT_FRAC_BITS;

    logic [XS_W-1:0]                 xs;
    logic [MS_W-1:0]                 ms;
    logic [CS_W-1:0]                 cs;
    logic [hsv2rgb_pkg::CH_W-1:0]    xch;
    logic [hsv2rgb_pkg::CH_W-1:0]    mch;
    logic [hsv2rgb_pkg::CH_W-1:0]    cch;
    logic [hsv2rgb_pkg::CH_W-1:0]    n_red;
    logic [hsv2rgb_pkg::CH_W-1:0]    n_green;
    logic [hsv2rgb_pkg::CH_W-1:0]    n_blue;
    logic                            r_valid;
    logic [hsv2rgb_pkg::CH_W-1:0]    r_red;
    logic [hsv2rgb_pkg::CH_W-1:0]    r_green;
    logic [hsv2rgb_pkg::CH_W-1:0]    r_blue;

    // The 60-degree denominator is 15 * 2^8, and 255 = 15 * 17
    always_comb begin
        xs  = {i_prod.vt, 4'b0000} + XS_W'(i_prod.vt);
        ms  = {i_prod.vum, 8'h00} - MS_W'(i_prod.vum);
        cs  = {i_prod.val, 8'h00} - CS_W'(i_prod.val);
        xch = xs[X_LO +: hsv2rgb_pkg::CH_W];
        mch = ms[M_LO +: hsv2rgb_pkg::CH_W];
        cch = cs[C_LO +: hsv2rgb_pkg::CH_W];
    end

    always_comb begin
        n_red   = mch;
        n_green = mch;
        n_blue  = mch;
        if (!i_prod.oor) begin
            case (i_prod.sector)
                hsv2rgb_pkg::SEC_R_G: begin n_red = cch; n_green = xch; end
                hsv2rgb_pkg::SEC_G_R: begin n_red = xch; n_green = cch; end
                hsv2rgb_pkg::SEC_G_B: begin n_green = cch; n_blue = xch; end
                hsv2rgb_pkg::SEC_B_G: begin n_green = xch; n_blue = cch; end
                hsv2rgb_pkg::SEC_B_R: begin n_red = xch; n_blue = cch; end
                hsv2rgb_pkg::SEC_R_B: begin n_red = cch; n_blue = xch; end
                default: begin n_red = mch; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ----- rtl/hsv_to_rgb_converter_core.sv -----
// HSV to RGB pixel converter, four-stage pipeline.
//
// Input channel: drive i_hue (degrees, 6 fraction bits), i_saturation and
// i_brightness (Q1.12, clamped to 1.0) and raise start for one cycle per
// item. An item is taken at every rising edge with start high and busy low;
// busy is held low, so a new item may enter on every cycle.
// Output channel: o_red, o_green and o_blue hold one result for exactly one
// cycle while o_strobe is high. The receiver cannot stall, so results leave
// in order with no back-pressure and no buffering is needed.
// Pipeline: an accepted item passes the registered stages in order (sector decode,
// saturation multiply, value multiply, channel scale) before its strobe.
// Throughput: one item per cycle; no stage ever stalls.
// Hue of 360 degrees or more sets every channel to the offset value * (1 - s).
// Reset (synchronous, active low) clears the valid bit of every stage, so no
// strobe follows reset until new items arrive; payload registers keep junk.
module hsv_to_rgb_converter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]     i_hue,
    input  logic [hsv2rgb_pkg::UNIT_W-1:0]    i_saturation,
    input  logic [hsv2rgb_pkg::UNIT_W-1:0]    i_brightness,
    output logic                              o_strobe,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]      o_blue
);

    logic                        take;
    logic                        sect_valid;
    hsv2rgb_pkg::t_sect_info     sect_info;
    logic                        prod_valid;
    hsv2rgb_pkg::t_prod          prod;

    // Never hold off the source: every stage advances on every cycle
    assign busy = 1'b0;
    assign take = start && !busy;

    // Stage A: clamp, find the sector and the offset within it
    hsv2rgb_sector u_sector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (sect_valid),
        .o_info       (sect_info)
    );

    // Stages B and C: saturation * distance, then value * both factors
    hsv2rgb_chroma u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sect_valid),
        .i_info  (sect_info),
        .o_valid (prod_valid),
        .o_prod  (prod)
    );

    // Stage D: scale to 8 bits, place the components, drive the result
    hsv2rgb_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .i_prod  (prod),
        .o_valid (o_strobe),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule
